@@ rtl/core/fmpp_pkg.sv @@
// Package for the feed motor speed controller and line pacer.
// Holds shared types and fixed constants; no dependencies.
package fmpp_pkg;

  localparam int QBITS = 16;
  localparam logic signed [39:0] RESET_HZ_Q = 40'sd14417920;
  localparam logic signed [39:0] INT_LIMIT = 40'sd2147418112;
  localparam logic [45:0] FREQ_NUM = 46'd65536000000;

  localparam logic [2:0] REG_LINE_TOTAL = 3'd0;
  localparam logic [2:0] REG_TARGET_HZ = 3'd1;
  localparam logic [2:0] REG_BASE_DUTY = 3'd2;
  localparam logic [2:0] REG_LEAD_IN = 3'd3;
  localparam logic [2:0] REG_RUN_OUT = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_FILT = 6'b000100,
    S_PI   = 6'b001000,
    S_CTRL = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic filt;
    logic pi;
    logic ctrl;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic div_done;
  } stat_t;

endpackage

@@ rtl/core/fmpp_ctrl.sv @@
// Controller state machine for the feed motor pacer.
// Uses fmpp_pkg; drives datapath commands and the stream handshakes.
module fmpp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fmpp_pkg::stat_t stat,
  output fmpp_pkg::cmd_t  cmd
);

  fmpp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmpp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == fmpp_pkg::S_IDLE);
  assign out_valid = (state == fmpp_pkg::S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      fmpp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.changed) state_next = fmpp_pkg::S_DIV;
        end
      end
      fmpp_pkg::S_DIV: begin
        if (stat.div_done) state_next = fmpp_pkg::S_FILT;
        else cmd.div_step = 1'b1;
      end
      fmpp_pkg::S_FILT: begin
        cmd.filt = 1'b1;
        state_next = fmpp_pkg::S_PI;
      end
      fmpp_pkg::S_PI: begin
        cmd.pi = 1'b1;
        state_next = fmpp_pkg::S_CTRL;
      end
      fmpp_pkg::S_CTRL: begin
        cmd.ctrl = 1'b1;
        state_next = fmpp_pkg::S_OUT;
      end
      fmpp_pkg::S_OUT: begin
        if (out_ready) state_next = fmpp_pkg::S_IDLE;
      end
      default: state_next = fmpp_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/fmpp_dp.sv @@
// Datapath for the feed motor pacer: pacing, serial divider, filter, PI law.
// Uses fmpp_pkg; sequenced by fmpp_ctrl.
module fmpp_dp #(
  parameter int MAX_LINES = 4096,
  parameter int PULSES_PER_STEP = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  fmpp_pkg::cmd_t  cmd,
  output fmpp_pkg::stat_t stat,
  input  logic            start_print,
  input  logic [31:0]     pulse_total,
  input  logic [23:0]     period_us,
  input  logic [12:0]     line_total,
  input  logic [9:0]      target_hz,
  input  logic [9:0]      base_duty,
  input  logic [9:0]      lead_in_steps,
  input  logic [9:0]      run_out_steps,
  output logic [9:0]      duty,
  output logic            line_valid,
  output logic [11:0]     line_index,
  output logic [15:0]     lost_pulses,
  output logic            sensor_power
);

  localparam logic [16:0] WIN_MAX = 17'(MAX_LINES);
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  logic [31:0] last_pulse_total;
  logic signed [39:0] filtered_hz, integral_sum, err;
  logic printing_on;
  logic [15:0] step_count;

  logic printing_t, pacing_hit;
  logic [15:0] step_t;
  logic [31:0] diff;
  logic [16:0] win, rel;

  always_comb begin
    printing_t = printing_on | start_print;
    step_t = start_print ? 16'd0 : step_count;
    diff = pulse_total - last_pulse_total;
    pacing_hit = printing_t && (pulse_total != last_pulse_total) &&
                 ((pulse_total % 32'(PULSES_PER_STEP)) == 32'd0);
    if (pacing_hit && step_t != 16'hFFFF) step_t = step_t + 16'd1;
    win = ({4'd0, line_total} > WIN_MAX) ? WIN_MAX : {4'd0, line_total};
    rel = {1'b0, step_t} - {7'd0, lead_in_steps};
  end

  assign stat.changed = (pulse_total != last_pulse_total);

  // Restoring divider, one quotient bit a cycle.
  logic [45:0] quo;
  logic [24:0] rem;
  logic [5:0] bit_cnt;
  logic [23:0] per;
  assign stat.div_done = (bit_cnt == 6'd0);

  logic [24:0] rem_sh;
  assign rem_sh = {rem[23:0], quo[45]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      per <= period_us;
      quo <= fmpp_pkg::FREQ_NUM;
      rem <= '0;
      bit_cnt <= 6'd46;
    end else if (cmd.div_step) begin
      bit_cnt <= bit_cnt - 6'd1;
      if (rem_sh >= {1'b0, per}) begin
        rem <= rem_sh - {1'b0, per};
        quo <= {quo[44:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[44:0], 1'b0};
      end
    end
  end

  // One shared reciprocal multiplier divides a magnitude by 10 or by 20.
  // The filter step uses floor((9f + x) / 10) = f + floor((x - f) / 10).
  logic signed [39:0] freq, dlt, q10, q20, sq10, sq20, filt_new, isum, ctl, t3;
  logic [31:0] div_mag;
  logic div_neg;
  logic [63:0] prod;

  always_comb begin
    if (per == 24'd0) freq = '0;
    else if (quo > 46'h7FFFFFFF) freq = 40'sh7FFFFFFF;
    else freq = $signed({8'd0, quo[31:0]});
    dlt = freq - filtered_hz;
    if (cmd.filt) begin
      div_neg = dlt[39];
      div_mag = dlt[39] ? 32'(40'sd9 - dlt) : dlt[31:0];
    end else if (cmd.pi) begin
      div_neg = err[39];
      div_mag = err[39] ? 32'(-err) : err[31:0];
    end else begin
      div_neg = integral_sum[39];
      div_mag = integral_sum[39] ? 32'(-integral_sum) : integral_sum[31:0];
    end
    prod = div_mag * RECIP10;
    q10 = $signed({11'd0, prod[63:35]});
    q20 = $signed({12'd0, prod[63:36]});
    sq10 = div_neg ? -q10 : q10;
    sq20 = div_neg ? -q20 : q20;
    filt_new = filtered_hz + sq10;
    isum = integral_sum + sq10;
    if (isum > fmpp_pkg::INT_LIMIT) isum = fmpp_pkg::INT_LIMIT;
    if (isum < -fmpp_pkg::INT_LIMIT) isum = -fmpp_pkg::INT_LIMIT;
    t3 = err * 3;
    ctl = $signed({14'd0, base_duty, 16'd0}) + t3 / 2 + sq20;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_total <= '0;
      filtered_hz <= fmpp_pkg::RESET_HZ_Q;
      integral_sum <= '0;
      printing_on <= 1'b0;
      step_count <= '0;
    end else begin
      if (cmd.load) begin
        printing_on <= printing_t;
        step_count <= step_t;
        if (stat.changed) begin
          last_pulse_total <= pulse_total;
          lost_pulses <= (diff - 32'd1 > 32'd65535) ? 16'hFFFF : 16'(diff - 32'd1);
          line_valid <= 1'b0;
          line_index <= '0;
          if (pacing_hit && step_t >= {6'd0, lead_in_steps} && rel < win) begin
            line_valid <= 1'b1;
            line_index <= rel[11:0];
          end
        end
      end
      if (cmd.filt) begin
        filtered_hz <= filt_new;
        err <= $signed({14'd0, target_hz, 16'd0}) - filt_new;
      end
      if (cmd.pi) begin
        integral_sum <= isum;
      end
      if (cmd.ctrl) begin
        if ({3'd0, step_count} > {6'd0, line_total} + {9'd0, run_out_steps}) begin
          printing_on <= 1'b0;
          duty <= '0;
          integral_sum <= '0;
        end else if (!printing_on) begin
          duty <= '0;
          integral_sum <= '0;
        end else if (ctl < 0) begin
          duty <= '0;
        end else if (ctl[39:16] > 24'd1023) begin
          duty <= 10'd1023;
        end else begin
          duty <= ctl[25:16];
        end
      end
    end
  end

  assign sensor_power = printing_on;

endmodule

@@ rtl/core/feed_motor_pi_speed_and_line_pacer.sv @@
// Top level of the feed motor PI speed controller and line pacer.
// Uses fmpp_pkg, fmpp_ctrl and fmpp_dp.
// An item with a changed pulse total passes through the 46-step serial frequency
// divider, then the filter, PI and control states; an unchanged item gives no result.
module feed_motor_pi_speed_and_line_pacer #(
  parameter int MAX_LINES = 4096,
  parameter int PULSES_PER_STEP = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pulse_total, period_us
  input  logic        s_tuser,   // start_print
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // duty, line_index, lost_pulses, zero pad
  output logic [1:0]  m_tuser,   // line_valid, sensor_power
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [12:0] line_total;
  logic [9:0] target_hz, base_duty, lead_in_steps, run_out_steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_total <= 13'd0;
      target_hz <= 10'd220;
      base_duty <= 10'd200;
      lead_in_steps <= 10'd150;
      run_out_steps <= 10'd300;
    end else if (cfg_we) begin
      case (cfg_index)
        fmpp_pkg::REG_LINE_TOTAL: line_total <= cfg_data;
        fmpp_pkg::REG_TARGET_HZ: target_hz <= cfg_data[9:0];
        fmpp_pkg::REG_BASE_DUTY: base_duty <= cfg_data[9:0];
        fmpp_pkg::REG_LEAD_IN: lead_in_steps <= cfg_data[9:0];
        fmpp_pkg::REG_RUN_OUT: run_out_steps <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  fmpp_pkg::cmd_t cmd;
  fmpp_pkg::stat_t stat;
  logic [9:0] duty;
  logic line_valid, sensor_power;
  logic [11:0] line_index;
  logic [15:0] lost_pulses;

  fmpp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .stat, .cmd
  );

  fmpp_dp #(.MAX_LINES(MAX_LINES), .PULSES_PER_STEP(PULSES_PER_STEP)) u_dp (
    .clk, .rst, .cmd, .stat,
    .start_print(s_tuser), .pulse_total(s_tdata[31:0]), .period_us(s_tdata[55:32]),
    .line_total, .target_hz, .base_duty, .lead_in_steps, .run_out_steps,
    .duty, .line_valid, .line_index, .lost_pulses, .sensor_power
  );

  assign m_tdata = {2'd0, lost_pulses, line_index, duty};
  assign m_tuser = {sensor_power, line_valid};

endmodule
